// ----- src/mep_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Escape-time pixel package
// Shared widths, types, register indexes and the design-time red-level
// threshold table for the escape-time pixel evaluator.
// ---------------------------------------------------------------------------
package mep_pkg;

  // Field widths
  localparam int C_W        = 32;  // signed point coordinate, Q4.28
  localparam int STEP_W     = 31;
  localparam int PIX_W      = 12;
  localparam int RED_W      = 8;
  localparam int OUT_CNT_W  = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Fixed-point arithmetic
  localparam int FRAC_BITS  = 28;
  localparam int MAG_W      = FRAC_BITS + 2;   // |z| <= 2.0
  localparam int SQ_W       = MAG_W + 1;       // truncated square <= 4.0
  localparam int Z_W        = C_W + 2;         // new z before the range test
  localparam int PPROD_W    = PIX_W + STEP_W;  // index * step
  localparam int PSUM_W     = PPROD_W + 2;     // origin + index * step

  localparam int ITER_LIMIT_DEF = 512;
  localparam int QUEUE_DEPTH    = 2;

  // Red-level thresholds
  localparam int THR_W     = 17;
  localparam int THR_N     = 256;
  localparam int LOG_FRAC  = 48;

  // Register reset values
  localparam logic signed [C_W-1:0] ORIGIN_REAL_RST = -32'sd481841644;
  localparam logic signed [C_W-1:0] ORIGIN_IMAG_RST = -32'sd5368709;
  localparam logic [STEP_W-1:0]     STEP_REAL_RST   = 31'd4682;
  localparam logic [STEP_W-1:0]     STEP_IMAG_RST   = 31'd7457;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_REAL = 2'd0,
    CFG_ORIGIN_IMAG = 2'd1,
    CFG_STEP_REAL   = 2'd2,
    CFG_STEP_IMAG   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [C_W-1:0] origin_real;
    logic signed [C_W-1:0] origin_imag;
    logic [STEP_W-1:0]     step_real;
    logic [STEP_W-1:0]     step_imag;
  } cfg_t;

  typedef struct packed {
    logic signed [C_W-1:0] cr;
    logic signed [C_W-1:0] ci;
  } point_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef logic [THR_N-1:0][THR_W-1:0] red_thr_t;

  // log2(n) with LOG_FRAC fractional bits, by repeated squaring
  function automatic logic [63:0] log2_fixed(input logic [63:0] n);
    int           e;
    logic [63:0]  y;
    logic [63:0]  frac;
    logic [127:0] sq;
    e    = 0;
    frac = '0;
    while (e < 62 && (n >> (e + 1)) != 64'd0) e++;
    y = n << (62 - e);
    for (int k = 0; k < LOG_FRAC; k++) begin
      sq   = {64'd0, y} * {64'd0, y};
      y    = sq[125:62];
      frac = frac << 1;
      if (y[63]) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  // thr[k]: smallest count whose red level reaches k (limit when never)
  function automatic red_thr_t red_thresholds(input int limit);
    red_thr_t    thr;
    logic [63:0] den;
    logic [63:0] num;
    int          k;
    den = log2_fixed(64'(limit));
    k   = 1;
    for (int i = 0; i < THR_N; i++) thr[i] = THR_W'(limit);
    thr[0] = '0;
    for (int n = 1; n < limit; n++) begin
      num = 64'd255 * log2_fixed(64'(n)) + (den >> 24);
      while (k < THR_N && num >= 64'(k) * den) begin
        thr[k] = THR_W'(n);
        k++;
      end
    end
    return thr;
  endfunction

endpackage
`default_nettype wire

// ----- src/mep_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Escape-time pixel front end
// Accepts pixel indexes, scales them by the step registers and forms the
// saturated point c for the queue.
// ---------------------------------------------------------------------------
module mep_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [mep_pkg::PIX_W-1:0] in_column,
  input  wire logic [mep_pkg::PIX_W-1:0] in_row,
  input  wire mep_pkg::cfg_t   cfg,
  input  wire mep_pkg::q_stat_t q_stat,
  output logic                 q_push,
  output mep_pkg::point_t      q_data
);
  import mep_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [PPROD_W-1:0]   col_prod_r, row_prod_r;
  logic                 accept;
  logic [PSUM_W-1:0]    sum_re, sum_im;

  function automatic logic [C_W-1:0] sat_c(input logic [PSUM_W-1:0] v);
    logic [C_W-1:0] res;
    if (!v[PSUM_W-1] && (|v[PSUM_W-2:C_W-1])) begin
      res = {1'b0, {(C_W-1){1'b1}}};
    end else if (v[PSUM_W-1] && !(&v[PSUM_W-2:C_W-1])) begin
      res = {1'b1, {(C_W-1){1'b0}}};
    end else begin
      res = v[C_W-1:0];
    end
    return res;
  endfunction

  assign in_stall = s1_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_valid_r && !q_stat.full;

  assign sum_re = {{(PSUM_W-C_W){cfg.origin_real[C_W-1]}}, cfg.origin_real}
                + PSUM_W'(col_prod_r);
  assign sum_im = {{(PSUM_W-C_W){cfg.origin_imag[C_W-1]}}, cfg.origin_imag}
                + PSUM_W'(row_prod_r);

  always_comb begin
    q_data.cr = sat_c(sum_re);
    q_data.ci = sat_c(sum_im);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept) begin
      col_prod_r <= PPROD_W'(in_column) * PPROD_W'(cfg.step_real);
      row_prod_r <= PPROD_W'(in_row) * PPROD_W'(cfg.step_imag);
    end
  end

endmodule
`default_nettype wire

// ----- src/mep_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Escape-time pixel point queue
// Short first-in first-out store of points between front and back end.
// ---------------------------------------------------------------------------
module mep_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mep_pkg::point_t  push_data,
  input  wire logic             pop,
  output mep_pkg::point_t       pop_data,
  output mep_pkg::q_stat_t      stat
);
  import mep_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  point_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign pop_data      = mem_r[rd_ptr_r];
  assign stat.full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.nonempty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/mep_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Escape-time pixel back end
// Iterates z = z^2 + c on one shared multiplier, then, for an escaping
// point, looks up the red level by a binary search of the threshold table.
// ---------------------------------------------------------------------------
module mep_back #(
  parameter int ITER_LIMIT = mep_pkg::ITER_LIMIT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mep_pkg::q_stat_t q_stat,
  input  wire mep_pkg::point_t  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [mep_pkg::RED_W-1:0]     out_red_level,
  output logic                          out_inside_set,
  output logic [mep_pkg::OUT_CNT_W-1:0] out_iteration_count
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(ITER_LIMIT);
  localparam logic [CNT_W-1:0]  LAST_N  = CNT_W'(ITER_LIMIT - 1);
  localparam logic [Z_W-1:0]    TWO_Z   = Z_W'(2) << FRAC_BITS;
  localparam logic [SQ_W:0]     FOUR_SQ = (SQ_W + 1)'(4) << FRAC_BITS;
  localparam red_thr_t          RED_THR = red_thresholds(ITER_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_MUL_RR, ST_MUL_II, ST_MUL_RI, ST_RED, ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic signed [C_W-1:0]  cr_r, cr_nxt, ci_r, ci_nxt;
  logic [Z_W-1:0]         zr_r, zr_nxt, zi_r, zi_nxt;
  logic [SQ_W-1:0]        sr_r, sr_nxt, si_r, si_nxt;
  logic [SQ_W:0]          p_r, p_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   inside_r, inside_nxt;
  logic [RED_W-1:0]       red_r, red_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [RED_W-1:0]       out_red_r, out_red_nxt;
  logic                   out_inside_r, out_inside_nxt;
  logic [OUT_CNT_W-1:0]   out_count_r, out_count_nxt;

  logic [Z_W-1:0]         mr, mi, nr, ni;
  logic                   out_of_range, escape_sq;
  logic [MAG_W-1:0]       mul_a, mul_b;
  logic [2*MAG_W-1:0]     prod;
  logic [SQ_W-1:0]        prod_sh;
  logic [SQ_W:0]          sum_sq;
  logic [RED_W-1:0]       cand;
  logic                   thr_hit;
  logic [31:0]            count_ext;

  assign mr = zr_r[Z_W-1] ? -zr_r : zr_r;
  assign mi = zi_r[Z_W-1] ? -zi_r : zi_r;
  assign out_of_range = (mr > TWO_Z) || (mi > TWO_Z);

  assign nr = Z_W'(sr_r) - Z_W'(si_r) + {{(Z_W-C_W){cr_r[C_W-1]}}, cr_r};
  assign ni = {{(Z_W-SQ_W-2){p_r[SQ_W]}}, p_r, 1'b0}
            + {{(Z_W-C_W){ci_r[C_W-1]}}, ci_r};

  // shared multiplier: squares first, cross product last
  assign mul_a   = (state_r == ST_MUL_II) ? mi[MAG_W-1:0] : mr[MAG_W-1:0];
  assign mul_b   = (state_r == ST_MUL_RR) ? mr[MAG_W-1:0] : mi[MAG_W-1:0];
  assign prod    = (2*MAG_W)'(mul_a) * (2*MAG_W)'(mul_b);
  assign prod_sh = prod[FRAC_BITS +: SQ_W];

  assign sum_sq    = {1'b0, sr_r} + {1'b0, si_r};
  assign escape_sq = sum_sq > FOUR_SQ;

  assign cand    = red_r | (RED_W'(1) << bit_r);
  assign thr_hit = RED_THR[cand] <= THR_W'(n_r);

  assign count_ext = inside_r ? 32'(ITER_LIMIT) : 32'(n_r);

  always_comb begin
    state_nxt      = state_r;
    cr_nxt         = cr_r;
    ci_nxt         = ci_r;
    zr_nxt         = zr_r;
    zi_nxt         = zi_r;
    sr_nxt         = sr_r;
    si_nxt         = si_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    inside_nxt     = inside_r;
    red_nxt        = red_r;
    bit_nxt        = bit_r;
    out_red_nxt    = out_red_r;
    out_inside_nxt = out_inside_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    q_pop          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_stat.nonempty) begin
          q_pop     = 1'b1;
          cr_nxt    = q_data.cr;
          ci_nxt    = q_data.ci;
          sr_nxt    = '0;
          si_nxt    = '0;
          p_nxt     = '0;
          n_nxt     = CNT_W'(1);
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        zr_nxt    = nr;
        zi_nxt    = ni;
        state_nxt = ST_MUL_RR;
      end
      ST_MUL_RR: begin
        if (out_of_range) begin
          inside_nxt = 1'b0;
          red_nxt    = '0;
          bit_nxt    = 3'd7;
          state_nxt  = ST_RED;
        end else begin
          sr_nxt    = prod_sh;
          state_nxt = ST_MUL_II;
        end
      end
      ST_MUL_II: begin
        si_nxt    = prod_sh;
        state_nxt = ST_MUL_RI;
      end
      ST_MUL_RI: begin
        if (escape_sq) begin
          inside_nxt = 1'b0;
          red_nxt    = '0;
          bit_nxt    = 3'd7;
          state_nxt  = ST_RED;
        end else begin
          p_nxt = (zr_r[Z_W-1] ^ zi_r[Z_W-1]) ? -{1'b0, prod_sh} : {1'b0, prod_sh};
          if (n_r == LAST_N) begin
            inside_nxt = 1'b1;
            red_nxt    = '0;
            state_nxt  = ST_DONE;
          end else begin
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = ST_ADD;
          end
        end
      end
      ST_RED: begin
        if (thr_hit) begin
          red_nxt = cand;
        end
        if (bit_r == 3'd0) begin
          state_nxt = ST_DONE;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_red_nxt    = red_r;
          out_inside_nxt = inside_r;
          out_count_nxt  = count_ext[OUT_CNT_W-1:0];
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cr_r         <= cr_nxt;
    ci_r         <= ci_nxt;
    zr_r         <= zr_nxt;
    zi_r         <= zi_nxt;
    sr_r         <= sr_nxt;
    si_r         <= si_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    inside_r     <= inside_nxt;
    red_r        <= red_nxt;
    bit_r        <= bit_nxt;
    out_red_r    <= out_red_nxt;
    out_inside_r <= out_inside_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_red_level       = out_red_r;
  assign out_inside_set      = out_inside_r;
  assign out_iteration_count = out_count_r;

endmodule
`default_nettype wire

// ----- src/mandelbrot_escape_time_pixel.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Escape-time pixel evaluator
// Per pixel index pair, forms c from the origin and step registers and
// returns the escape iteration, an inside flag and a log-scaled red level.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction carries a column and
//   a row. The front end takes a transaction whenever its one-deep product
//   stage is free or can move into the point queue (two entries).
//   Result channel (out_valid / out_stall): one transaction per pixel, in
//   input order, held in an output register until the receiver takes it;
//   the back end meanwhile starts the next queued point.
//   Configuration: write cfg_data to register cfg_index with cfg_write,
//   only while no pixel is in flight.
//   Sequencing: the back end loads a point, then runs each iteration as one
//   add followed by three products on the single shared multiplier, then
//   does the red-level search and hands off to the output register. It works
//   on one point at a time; further points wait in the queue.
//   Reset (rst_n low, synchronous) empties front, queue and back end and
//   restores the default view registers. A stalled receiver holds the
//   result; the queue then fills and in_stall rises.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int ITER_LIMIT = mep_pkg::ITER_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_write,
  input  wire logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [mep_pkg::PIX_W-1:0]         in_column,
  input  wire logic [mep_pkg::PIX_W-1:0]         in_row,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mep_pkg::RED_W-1:0]              out_red_level,
  output logic                                   out_inside_set,
  output logic [mep_pkg::OUT_CNT_W-1:0]          out_iteration_count
);
  import mep_pkg::*;

  cfg_t    cfg_r;
  q_stat_t q_stat;
  point_t  q_push_data, q_pop_data;
  logic    q_push, q_pop;

  // View registers: decode the index and keep the low bits of the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_real <= ORIGIN_REAL_RST;
      cfg_r.origin_imag <= ORIGIN_IMAG_RST;
      cfg_r.step_real   <= STEP_REAL_RST;
      cfg_r.step_imag   <= STEP_IMAG_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_REAL: cfg_r.origin_real <= cfg_data[C_W-1:0];
        CFG_ORIGIN_IMAG: cfg_r.origin_imag <= cfg_data[C_W-1:0];
        CFG_STEP_REAL:   cfg_r.step_real   <= cfg_data[STEP_W-1:0];
        CFG_STEP_IMAG:   cfg_r.step_imag   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: scale indexes, saturate c, push to the queue
  mep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_column (in_column),
    .in_row    (in_row),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // Queue: decouple the fast front from the iterating back end
  mep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  // Back: iterate, grade the escape count, drive the result register
  mep_back #(
    .ITER_LIMIT (ITER_LIMIT)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_data              (q_pop_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red_level       (out_red_level),
    .out_inside_set      (out_inside_set),
    .out_iteration_count (out_iteration_count)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("point pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.nonempty)
    else $error("point popped from an empty queue");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_set) |-> (out_red_level == '0))
    else $error("inside pixel with non-zero red level");

  a_stall_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full)
    else $error("input stalled while the queue has room");
`endif

endmodule
`default_nettype wire

// ----- tb/escape_time_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-time pixel checker
// Follows the view register writes and both channels of the pixel
// evaluator. Works out each accepted pixel's escape result and compares
// every result transaction, field by field, with the oldest one owed.
// ---------------------------------------------------------------------------
module escape_time_checker #(
  parameter int ITER_LIMIT = mep_pkg::ITER_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [mep_pkg::PIX_W-1:0]         in_column,
  input  logic [mep_pkg::PIX_W-1:0]         in_row,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [mep_pkg::RED_W-1:0]         out_red_level,
  input  logic                              out_inside_set,
  input  logic [mep_pkg::OUT_CNT_W-1:0]     out_iteration_count,
  output int                                mismatches,
  output int                                pixels_owed
);
  import mep_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]     col;
    logic [PIX_W-1:0]     row;
    logic [RED_W-1:0]     red;
    logic                 in_set;
    logic [OUT_CNT_W-1:0] count;
  } pixel_result_t;

  localparam logic [63:0] TWO_Q  = 64'd2 << FRAC_BITS;
  localparam logic [63:0] FOUR_Q = 64'd4 << FRAC_BITS;
  localparam longint      C_MAX  = 2147483647;
  localparam longint      C_MIN  = -C_MAX - 1;

  cfg_t             view;
  pixel_result_t    owed_pixels[$];
  pixel_result_t    oldest;
  logic [RED_W-1:0] red_of_count [ITER_LIMIT];

  // Exact unsigned product, shifted right
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] abs_q(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Product of two fixed-point values, magnitude truncated, sign reapplied
  function automatic longint q_mul(input longint a, input longint b);
    logic [63:0] m;
    m = mul_shift(abs_q(a), abs_q(b), FRAC_BITS);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  // log2 with LOG_FRAC fraction bits: integer part from the top set bit,
  // fraction one bit per squaring of the normalised mantissa
  function automatic logic [63:0] log2_q48(input logic [63:0] n);
    int          top;
    logic [63:0] y;
    logic [63:0] bits;
    top  = 62;
    bits = '0;
    while (top > 0 && !n[top]) top--;
    y = n << (62 - top);
    for (int k = 0; k < LOG_FRAC; k++) begin
      y    = mul_shift(y, y, 62);
      bits = bits << 1;
      if (y[63]) begin
        bits[0] = 1'b1;
        y       = y >> 1;
      end
    end
    return (64'(top) << LOG_FRAC) | bits;
  endfunction

  function automatic pixel_result_t escape_pixel(input logic [PIX_W-1:0] col,
                                                 input logic [PIX_W-1:0] row);
    pixel_result_t res;
    longint        cr;
    longint        ci;
    longint        zr;
    longint        zi;
    longint        nr;
    longint        ni;
    logic [63:0]   mr;
    logic [63:0]   mi;
    int            n;
    bit            gone;
    cr = clamp32(longint'($signed(view.origin_real)) + longint'(col) * longint'(view.step_real));
    ci = clamp32(longint'($signed(view.origin_imag)) + longint'(row) * longint'(view.step_imag));
    zr   = 0;
    zi   = 0;
    n    = 1;
    gone = 1'b0;
    while (n < ITER_LIMIT && !gone) begin
      nr = q_mul(zr, zr) - q_mul(zi, zi) + cr;
      ni = 2 * q_mul(zr, zi) + ci;
      mr = abs_q(nr);
      mi = abs_q(ni);
      if (mr > TWO_Q || mi > TWO_Q ||
          mul_shift(mr, mr, FRAC_BITS) + mul_shift(mi, mi, FRAC_BITS) > FOUR_Q) begin
        gone = 1'b1;
      end else begin
        zr = nr;
        zi = ni;
        n++;
      end
    end
    res.col    = col;
    res.row    = row;
    res.in_set = !gone;
    res.count  = OUT_CNT_W'(n);
    res.red    = gone ? red_of_count[n] : '0;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Red level per escape count, floor of the log ratio with a small bias
  initial begin : build_red_table
    logic [63:0] den;
    logic [63:0] q;
    den = log2_q48(64'(ITER_LIMIT));
    red_of_count[0] = '0;
    for (int n = 1; n < ITER_LIMIT; n++) begin
      q = (64'd255 * log2_q48(64'(n)) + (den >> 24)) / den;
      red_of_count[n] = (q > 64'd255) ? 8'd255 : RED_W'(q);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      view.origin_real = ORIGIN_REAL_RST;
      view.origin_imag = ORIGIN_IMAG_RST;
      view.step_real   = STEP_REAL_RST;
      view.step_imag   = STEP_IMAG_RST;
      owed_pixels.delete();
      mismatches = 0;
      pixels_owed <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ORIGIN_REAL: view.origin_real = cfg_data;
          CFG_ORIGIN_IMAG: view.origin_imag = cfg_data;
          CFG_STEP_REAL:   view.step_real   = cfg_data[STEP_W-1:0];
          CFG_STEP_IMAG:   view.step_imag   = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_pixels.size() == 0) begin
          flag_mismatch($sformatf("result (red %0d, inside %0d, count %0d) with none owed",
                                  out_red_level, out_inside_set, out_iteration_count));
        end else begin
          oldest = owed_pixels.pop_front();
          if (out_red_level !== oldest.red)
            flag_mismatch($sformatf("pixel (%0d,%0d) red_level %0d, expected %0d",
                                    oldest.col, oldest.row, out_red_level, oldest.red));
          if (out_inside_set !== oldest.in_set)
            flag_mismatch($sformatf("pixel (%0d,%0d) inside_set %0d, expected %0d",
                                    oldest.col, oldest.row, out_inside_set, oldest.in_set));
          if (out_iteration_count !== oldest.count)
            flag_mismatch($sformatf("pixel (%0d,%0d) iteration_count %0d, expected %0d",
                                    oldest.col, oldest.row, out_iteration_count,
                                    oldest.count));
        end
      end
      if (in_valid && !in_stall) owed_pixels.push_back(escape_pixel(in_column, in_row));
      pixels_owed <= owed_pixels.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-time pixel testbench
// Drives pixel transactions through a series of views (reset view, exact
// grid points, saturating and minimum corners, the cusp, a wide overview,
// a boundary zoom, random register values) with random idling on both
// channels; the checker instance predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import mep_pkg::*;

  // Longest quiet stretch of a correct run is one inside pixel plus a
  // stall; allow several times that.
  localparam int WATCHDOG_LIMIT = 20000;
  // Settle time after the last result before a register write or the end
  localparam int SETTLE_CYCLES  = 16;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ORIGIN_REAL;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_column = '0;
  logic [PIX_W-1:0]      in_row    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RED_W-1:0]      out_red_level;
  logic                  out_inside_set;
  logic [OUT_CNT_W-1:0]  out_iteration_count;

  int fail_total;
  int owed;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;  // no idling on either side while set

  mandelbrot_escape_time_pixel u_dut (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_column, .in_row,
    .out_valid, .out_stall, .out_red_level, .out_inside_set, .out_iteration_count
  );

  escape_time_checker u_checker (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_column, .in_row,
    .out_valid, .out_stall, .out_red_level, .out_inside_set, .out_iteration_count,
    .mismatches(fail_total), .pixels_owed(owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: after each result transaction draw a stall, then hold the next
  // result for that many valid cycles before taking it.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, 11);
      else if (out_valid && stall_left > 0) stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one pixel after a random gap; return at the edge that takes it,
  // leaving valid high so a back-to-back transaction needs no second edit.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load all four view registers while the block is idle
  task automatic write_view(input logic [31:0] o_re, input logic [31:0] o_im,
                            input logic [31:0] s_re, input logic [31:0] s_im);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_ORIGIN_REAL;
    cfg_data  <= o_re;
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_IMAG;
    cfg_data  <= o_im;
    @(posedge clk);
    cfg_index <= CFG_STEP_REAL;
    cfg_data  <= s_re;
    @(posedge clk);
    cfg_index <= CFG_STEP_IMAG;
    cfg_data  <= s_im;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random pixels over the whole index range; switch idling in blocks
  task automatic scatter_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset view: index extremes and alternating bit patterns
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);

    // Grid with c = -2 + index/1024 on both axes: exact landmark points
    write_view(-32'sd536870912, -32'sd536870912, 32'd262144, 32'd262144);
    send_pixel(12'd0, 12'd0);        // c = -2-2i, escapes on the first pass
    send_pixel(12'd0, 12'd2048);     // c = -2, |z|^2 sits at exactly 4
    send_pixel(12'd2048, 12'd2048);  // c = 0
    send_pixel(12'd2048, 12'd3072);  // c = i, bounded cycle
    send_pixel(12'd1024, 12'd2048);  // c = -1, period two
    send_pixel(12'd4095, 12'd2048);  // just under c = 2, escapes on the second pass
    send_pixel(12'd2305, 12'd2048);  // just past the cusp, slow escape

    // Saturating corner: largest origins and steps, top data bit set
    write_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'h555, 12'hAAA);

    // Minimum origins with zero steps: every pixel at c = -8-8i
    write_view(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'hAAA, 12'h555);

    // Cusp at c = 0.25 with a tiny real step: long escapes near the limit
    write_view(32'd67108864, 32'd0, 32'd4, 32'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd3000, 12'd1);

    // Wide overview, -2.5..1.5 by -1.5..1.5
    write_view(-32'sd671088640, -32'sd402653184, 32'd262144, 32'd196608);
    scatter_pixels(200);

    // Fully random register values, mostly far outside the set
    for (int v = 0; v < 4; v++) begin
      write_view($urandom, $urandom, $urandom, $urandom);
      scatter_pixels(25);
    end

    // Reset values written back explicitly
    write_view(ORIGIN_REAL_RST, ORIGIN_IMAG_RST, 32'(STEP_REAL_RST), 32'(STEP_IMAG_RST));
    scatter_pixels(60);

    // Boundary zoom in the valley near -0.75 + 0.1i
    write_view(-32'sd201326592, 32'd26843545, 32'd128, 32'd128);
    scatter_pixels(40);

    // Real axis only: zero imaginary step
    write_view(-32'sd671088640, 32'd0, 32'd262144, 32'd0);
    scatter_pixels(60);

    // Largest steps from random origins, saturating almost everywhere
    write_view($urandom, $urandom, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    scatter_pixels(40);

    // Overview again
    write_view(-32'sd671088640, -32'sd402653184, 32'd262144, 32'd196608);
    scatter_pixels(80);

    settle();
    if (fail_total == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
